FILE: hw/rtl/m3i_pkg.sv
// shared types and constants for the 3x3 matrix inverse
package m3i_pkg;

  localparam int ELEM_W     = 16;              // Q8.8 input element
  localparam int INV_W      = 32;              // Q16.16 inverse element
  localparam int COF_W      = 33;              // exact cofactor, signed
  localparam int DET_W      = 49;              // exact determinant, signed
  localparam int DET_OUT_W  = 48;              // determinant field, saturated
  localparam int DEN_W      = 48;              // determinant magnitude
  localparam int FRAC_SHIFT = 24;              // numerator scale
  localparam int NUM_W      = 32 + FRAC_SHIFT; // cofactor magnitude times 2^24
  localparam int DIV_STEPS  = NUM_W;           // one quotient bit per stage
  localparam int FRONT_LAT  = 4;               // products, cofactors, terms, sum
  // front, lane input, divide steps, lane output
  localparam int PIPE_LAT   = FRONT_LAT + 1 + DIV_STEPS + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [INV_W-1:0]  inv_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02;
    elem_t a10; elem_t a11; elem_t a12;
    elem_t a20; elem_t a21; elem_t a22;
  } mat_item_t;

  typedef struct packed {
    inv_t inv00; inv_t inv01; inv_t inv02;
    inv_t inv10; inv_t inv11; inv_t inv12;
    inv_t inv20; inv_t inv21; inv_t inv22;
    logic signed [DET_OUT_W-1:0] determinant;
    logic singular;
    logic saturated;
  } res_item_t;

endpackage

FILE: hw/rtl/m3i_if.sv
// valid/ready channels for matrix items and result items
interface m3i_mat_if import m3i_pkg::*; ();
  logic      valid;
  logic      ready;
  mat_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m3i_res_if import m3i_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/m3i_front.sv
// cofactor and determinant pipeline, four register stages
module m3i_front import m3i_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  mat_item_t m,
  output cof_t      cof [9],
  output det_t      det
);

  logic signed [31:0] p [18];
  elem_t              col1 [3];
  elem_t              col2 [3];
  cof_t               cof2 [9];
  cof_t               cof3 [9];
  det_t               t [3];

  // stage 1: pairwise products of the 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= m.a22 * m.a11;  p[1]  <= m.a21 * m.a12;
      p[2]  <= m.a21 * m.a02;  p[3]  <= m.a22 * m.a01;
      p[4]  <= m.a12 * m.a01;  p[5]  <= m.a11 * m.a02;
      p[6]  <= m.a20 * m.a12;  p[7]  <= m.a22 * m.a10;
      p[8]  <= m.a22 * m.a00;  p[9]  <= m.a20 * m.a02;
      p[10] <= m.a10 * m.a02;  p[11] <= m.a12 * m.a00;
      p[12] <= m.a21 * m.a10;  p[13] <= m.a20 * m.a11;
      p[14] <= m.a20 * m.a01;  p[15] <= m.a21 * m.a00;
      p[16] <= m.a11 * m.a00;  p[17] <= m.a10 * m.a01;
      col1[0] <= m.a00;
      col1[1] <= m.a10;
      col1[2] <= m.a20;
    end
  end

  // stage 2: adjugate entries
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        cof2[k] <= {p[2*k][31], p[2*k]} - {p[2*k+1][31], p[2*k+1]};
      end
      col2 <= col1;
    end
  end

  // stage 3: column 0 expansion terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t[i] <= col2[i] * cof2[i];
      end
      cof3 <= cof2;
    end
  end

  // stage 4: exact determinant, the true value always fits
  always_ff @(posedge clk) begin
    if (en) begin
      det <= t[0] + t[1] + t[2];
      cof <= cof3;
    end
  end

endmodule

FILE: hw/rtl/m3i_lane.sv
// one inverse element: restoring divide lane with sign and saturation
module m3i_lane import m3i_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  cof_t                       cof,
  input  logic [DIV_STEPS:0][DEN_W-1:0] dmag,
  input  logic                       dneg,
  output inv_t                       q,
  output logic                       sat
);

  logic [DEN_W-1:0] rem  [DIV_STEPS+1];
  logic [NUM_W-1:0] nq   [DIV_STEPS+1];
  logic             cneg [DIV_STEPS+1];
  logic [COF_W-1:0] cmag;
  logic [NUM_W-1:0] mag;
  logic             neg;
  logic             big_pos;
  logic             big_neg;

  // lane input: scaled numerator magnitude
  assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      nq[0]   <= {cmag[31:0], {FRAC_SHIFT{1'b0}}};
      cneg[0] <= cof[COF_W-1];
    end
  end

  // one quotient bit per stage, numerator bits shift out as quotient shifts in
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[j], nq[j][NUM_W-1]};
    assign ge    = trial >= {1'b0, dmag[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? DEN_W'(trial - {1'b0, dmag[j]}) : trial[DEN_W-1:0];
        nq[j+1]   <= {nq[j][NUM_W-2:0], ge};
        cneg[j+1] <= cneg[j];
      end
    end
  end

  // sign and clip to Q16.16
  assign mag     = nq[DIV_STEPS];
  assign neg     = cneg[DIV_STEPS] ^ dneg;
  assign big_pos = mag[NUM_W-1:31] != '0;
  assign big_neg = (mag[NUM_W-1:32] != '0) || (mag[31] && (mag[30:0] != '0));

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg) begin
        q   <= big_neg ? inv_t'({1'b1, 31'b0}) : inv_t'(-mag[31:0]);
        sat <= big_neg;
      end else begin
        q   <= big_pos ? inv_t'({1'b0, {31{1'b1}}}) : inv_t'(mag[31:0]);
        sat <= big_pos;
      end
    end
  end

endmodule

FILE: hw/rtl/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate, nine divide lanes and a merge stage
// pipeline from input transfer to result valid: 4 front stages,
// lane input, 56 one-bit divide stages, lane output, output register
// throughput: one matrix per cycle while the output does not stall, set by the fully pipelined divide lanes
// the whole pipeline holds while a result waits and the sink is not ready
// reset clears the stage valid bits and the output valid, not the data
module matrix3_inverse import m3i_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  m3i_mat_if.sink    mat,
  m3i_res_if.source  res
);

  logic                          en;
  logic [PIPE_LAT-1:0]           vld;
  cof_t                          cof [9];
  det_t                          det;
  logic [DIV_STEPS:0][DEN_W-1:0] sb_d;
  logic [DIV_STEPS:0]            sb_neg;
  logic [DET_OUT_W-1:0]          sb_det [DIV_STEPS+1];
  logic [DIV_STEPS:0]            sb_sing;
  logic [DET_OUT_W-1:0]          fin_det;
  logic                          fin_sing;
  inv_t                          q [9];
  logic [8:0]                    sat;
  det_t                          dabs;
  logic                          res_valid;
  res_item_t                     res_data;

  assign en        = !res_valid || res.ready;
  assign mat.ready = en;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], mat.valid};
    end
  end

  m3i_front u_front (
    .clk (clk),
    .en  (en),
    .m   (mat.data),
    .cof (cof),
    .det (det)
  );

  // determinant sideband: magnitude, sign, clipped field, singular
  assign dabs = det[DET_W-1] ? -det : det;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_d[0]    <= dabs[DEN_W-1:0];
      sb_neg[0]  <= det[DET_W-1];
      sb_sing[0] <= det == '0;
      if (det[DET_W-1] != det[DET_W-2]) begin
        sb_det[0] <= det[DET_W-1] ? {1'b1, {(DET_OUT_W-1){1'b0}}}
                                  : {1'b0, {(DET_OUT_W-1){1'b1}}};
      end else begin
        sb_det[0] <= det[DET_OUT_W-1:0];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        sb_d[k+1]    <= sb_d[k];
        sb_neg[k+1]  <= sb_neg[k];
        sb_det[k+1]  <= sb_det[k];
        sb_sing[k+1] <= sb_sing[k];
      end
      fin_det  <= sb_det[DIV_STEPS];
      fin_sing <= sb_sing[DIV_STEPS];
    end
  end

  // nine divide lanes
  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cof  (cof[i]),
      .dmag (sb_d),
      .dneg (sb_neg[DIV_STEPS]),
      .q    (q[i]),
      .sat  (sat[i])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data.inv00       <= fin_sing ? '0 : q[0];
      res_data.inv01       <= fin_sing ? '0 : q[1];
      res_data.inv02       <= fin_sing ? '0 : q[2];
      res_data.inv10       <= fin_sing ? '0 : q[3];
      res_data.inv11       <= fin_sing ? '0 : q[4];
      res_data.inv12       <= fin_sing ? '0 : q[5];
      res_data.inv20       <= fin_sing ? '0 : q[6];
      res_data.inv21       <= fin_sing ? '0 : q[7];
      res_data.inv22       <= fin_sing ? '0 : q[8];
      res_data.determinant <= fin_det;
      res_data.singular    <= fin_sing;
      res_data.saturated   <= !fin_sing && (sat != '0);
    end
  end

  // singular results carry a zero determinant and nothing else
  a_sing_det : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.singular == (res.data.determinant == '0)))
    else $error("singular flag disagrees with determinant");

  a_sing_zero : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.singular |-> !res.data.saturated &&
      res.data.inv00 == '0 && res.data.inv11 == '0 && res.data.inv22 == '0)
    else $error("singular result with nonzero inverse");

  // a held result freezes the pipeline
  a_hold : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> $stable(vld) && res.valid)
    else $error("pipeline moved while result stalled");

endmodule

FILE: tb/sv/m3i_tb_checker.sv
// checker for the 3x3 matrix inverse: predicts each result and compares it
module m3i_tb_checker import m3i_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  m3i_mat_if        mat,
  m3i_res_if        res,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  res_item_t inverse_q[$];

  // exact adjugate inverse in fixed point, saturated
  function automatic res_item_t invert_matrix(mat_item_t m);
    longint e[9];
    longint cof[9];
    longint det, q, num;
    longint lo32, hi32;
    longint dmax, dmin;
    res_item_t r;
    inv_t invs[9];
    e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
    e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
    e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
    lo32 = -64'sd2147483648;
    hi32 = 64'sd2147483647;
    dmax = 64'sd140737488355327;
    dmin = -64'sd140737488355328;
    cof[0] = e[8]*e[4] - e[7]*e[5];
    cof[1] = e[7]*e[2] - e[8]*e[1];
    cof[2] = e[5]*e[1] - e[4]*e[2];
    cof[3] = e[6]*e[5] - e[8]*e[3];
    cof[4] = e[8]*e[0] - e[6]*e[2];
    cof[5] = e[3]*e[2] - e[5]*e[0];
    cof[6] = e[7]*e[3] - e[6]*e[4];
    cof[7] = e[6]*e[1] - e[7]*e[0];
    cof[8] = e[4]*e[0] - e[3]*e[1];
    det = e[0]*cof[0] + e[3]*cof[1] + e[6]*cof[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      num = cof[k] <<< FRAC_SHIFT;
      q = num / det;
      if (q > hi32) begin
        q = hi32;
        r.saturated = 1'b1;
      end else if (q < lo32) begin
        q = lo32;
        r.saturated = 1'b1;
      end
      invs[k] = q[INV_W-1:0];
    end
    r.inv00 = invs[0]; r.inv01 = invs[1]; r.inv02 = invs[2];
    r.inv10 = invs[3]; r.inv11 = invs[4]; r.inv12 = invs[5];
    r.inv20 = invs[6]; r.inv21 = invs[7]; r.inv22 = invs[8];
    if (det > dmax) det = dmax;
    else if (det < dmin) det = dmin;
    r.determinant = det[DET_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  // predict on matrix transfer, compare on result transfer
  always @(posedge clk) begin
    res_item_t want, got;
    if (!rst) begin
      if (mat.valid && mat.ready) inverse_q.push_back(invert_matrix(mat.data));
      if (res.valid && res.ready) begin
        got = res.data;
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = inverse_q.pop_front();
          if (got.inv00 != want.inv00) report_mismatch("inv00", got.inv00, want.inv00);
          if (got.inv01 != want.inv01) report_mismatch("inv01", got.inv01, want.inv01);
          if (got.inv02 != want.inv02) report_mismatch("inv02", got.inv02, want.inv02);
          if (got.inv10 != want.inv10) report_mismatch("inv10", got.inv10, want.inv10);
          if (got.inv11 != want.inv11) report_mismatch("inv11", got.inv11, want.inv11);
          if (got.inv12 != want.inv12) report_mismatch("inv12", got.inv12, want.inv12);
          if (got.inv20 != want.inv20) report_mismatch("inv20", got.inv20, want.inv20);
          if (got.inv21 != want.inv21) report_mismatch("inv21", got.inv21, want.inv21);
          if (got.inv22 != want.inv22) report_mismatch("inv22", got.inv22, want.inv22);
          if (got.determinant != want.determinant)
            report_mismatch("determinant", got.determinant, want.determinant);
          if (got.singular != want.singular)
            report_mismatch("singular", got.singular, want.singular);
          if (got.saturated != want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
        end
      end
    end
    // outstanding predictions for the stimulus, updated with a nonblocking assignment
    pending <= inverse_q.size();
  end
endmodule

FILE: tb/sv/tb.sv
// testbench top: stimulus, result stalls and verdict for matrix3_inverse
module tb;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, cycles;
  logic calm;

  m3i_mat_if mat ();
  m3i_res_if res ();

  matrix3_inverse i_dut (.clk(clk), .rst(rst), .mat(mat), .res(res));
  m3i_tb_checker i_chk (.clk(clk), .rst(rst), .mat(mat), .res(res),
                        .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    mat.valid = 1'b0;
    mat.data  = '0;
    res.ready = 1'b0;
    calm      = 1'b0;
  end

  // result stalls, none during the calm stretch
  always @(posedge clk)
    res.ready <= calm || ($urandom_range(99) >= 10);

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL matrix3_inverse");
      $finish;
    end
  end
  initial cycles = 0;

  function automatic elem_t pick_elem();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return elem_t'($urandom_range(511)) - 16'sd256;
      4: return 16'sd256;
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic mat_item_t fill_all(elem_t v);
    return '{v, v, v, v, v, v, v, v, v};
  endfunction

  function automatic mat_item_t diag(elem_t x, elem_t y, elem_t z);
    mat_item_t m;
    m = '0;
    m.a00 = x; m.a11 = y; m.a22 = z;
    return m;
  endfunction

  // one matrix transfer, with an occasional idle cycle first
  task automatic send_matrix(mat_item_t m);
    if (!calm && $urandom_range(99) < 10) begin
      mat.valid <= 1'b0;
      @(posedge clk);
    end
    mat.valid <= 1'b1;
    mat.data  <= m;
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
  endtask

  task automatic drain();
    mat.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    mat_item_t m;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, scalings, zeros, extremes, singular, overflow
    send_matrix(diag(16'sd256, 16'sd256, 16'sd256));
    send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
    send_matrix(diag(16'sd1, 16'sd256, -16'sd1));
    send_matrix(diag(16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000));
    send_matrix(diag(16'sh8000, 16'sh7fff, 16'sh8000));
    send_matrix('0);
    send_matrix(fill_all(16'sh7fff));
    send_matrix(fill_all(16'sh8000));
    send_matrix(fill_all(-16'sd1));
    // determinant just below +2^47
    m = fill_all(16'sh8000);
    m.a01 = 16'sh7fff; m.a01 = 16'sh8000;
    m.a00 = 16'sh8000; m.a11 = 16'sh8000; m.a22 = 16'sh8000;
    m.a01 = 16'sh7fff; m.a12 = 16'sh7fff; m.a20 = 16'sh7fff;
    m.a02 = 16'sh7fff; m.a10 = 16'sh7fff; m.a21 = 16'sh7fff;
    send_matrix(m);
    m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000};
    send_matrix(m);
    m = '{16'sh8000, 16'sh0, 16'sh0, 16'sh0, 16'sh8000, 16'sh8000,
          16'sh0, 16'sh7fff, 16'sh8000};
    send_matrix(m);
    m = '{16'sd256, 16'sd512, 16'sd768, 16'sd1024, 16'sd1280, 16'sd1536,
          16'sd1792, 16'sd2048, 16'sd2304};
    send_matrix(m);
    m = '{16'sd2, 16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'sd1, 16'sd0, 16'sd1, 16'sd2};
    send_matrix(m);
    m = '{16'sh7fff, 16'sh7ffe, 16'sd0, 16'sh7ffe, 16'sh7ffd, 16'sd0,
          16'sd0, 16'sd0, 16'sd1};
    send_matrix(m);
    m = '{-16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0};
    send_matrix(m);

    // hold off until everything has come back
    drain();

    // random matrices, with a calm stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 900);
      if (n == 1200) drain();
      m.a00 = pick_elem(); m.a01 = pick_elem(); m.a02 = pick_elem();
      m.a10 = pick_elem(); m.a11 = pick_elem(); m.a12 = pick_elem();
      m.a20 = pick_elem(); m.a21 = pick_elem(); m.a22 = pick_elem();
      // sometimes make it singular by copying a row
      if ($urandom_range(19) == 0) begin
        m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end
      send_matrix(m);
    end
    calm = 1'b0;

    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS matrix3_inverse");
    else
      $display("FAIL matrix3_inverse");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_if.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_lane.sv
hw/rtl/matrix3_inverse.sv
tb/sv/m3i_tb_checker.sv
tb/sv/tb.sv
